// ----- design/trailing_window_average_core_macros.svh -----
// Assertion macros shared by the trailing window average modules.
`ifndef TRAILING_WINDOW_AVERAGE_CORE_MACROS_SVH
`define TRAILING_WINDOW_AVERAGE_CORE_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define TWA_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Check that cond holds in the cycle after trig.
`define TWA_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ----- design/twa_pkg.sv -----
// Shared constants and control types for the trailing window average core.
package twa_pkg;

	localparam int MAX_WINDOW   = 1024;
	localparam int WINDOW_RESET = 50;
	localparam int DATA_W       = 32;
	localparam int WIN_W        = 11;
	localparam int SLOT_W       = 10;
	localparam int SUM_W        = 42;
	localparam int NUM_W        = SUM_W + 1;
	localparam int DEN_W        = WIN_W + 1;
	localparam int DIV_STEPS    = NUM_W;
	localparam int DIV_CNT_W    = 6;

	typedef struct packed {
		logic accept;
		logic update;
		logic flag;
		logic load;
		logic step;
		logic finish;
	} twa_cmd_t;

	typedef struct packed {
		logic last;
		logic too_few;
	} twa_status_t;

endpackage

// ----- design/trailing_window_average_core.sv -----
// Top level: trailing window average of signed Q16.16 samples.
// Each item runs accept with ring read, then sum update and ring write.
// A marked item then runs load, a serial divide (one quotient bit per cycle) and sign,
// then its result strobes; a too-few flag strobes from the update state, with no divide.
// The receiver cannot stall: done is high for exactly one cycle per result.
// Reset clears window sum, count and write slot and sets the window length to 50; ring contents are kept.
module trailing_window_average_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [twa_pkg::DATA_W-1:0] sample,
	input  logic                              is_last,
	output logic                              done,
	output logic signed [twa_pkg::DATA_W-1:0] average,
	output logic                              too_few,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [twa_pkg::WIN_W-1:0]         cfg_data
);
	import twa_pkg::*;

	twa_cmd_t    cmd;
	twa_status_t status;

	twa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.done      (done),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.status    (status)
	);

	twa_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.sample   (sample),
		.is_last  (is_last),
		.average  (average),
		.too_few  (too_few)
	);

endmodule

// ----- design/twa_dpath.sv -----
// Datapath: sample ring, window sum, sample count and serial divider.
`include "trailing_window_average_core_macros.svh"

module twa_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  twa_pkg::twa_cmd_t           cmd,
	output twa_pkg::twa_status_t        status,
	input  logic                        cfg_we,
	input  logic [twa_pkg::WIN_W-1:0]   cfg_data,
	input  logic signed [twa_pkg::DATA_W-1:0] sample,
	input  logic                        is_last,
	output logic signed [twa_pkg::DATA_W-1:0] average,
	output logic                        too_few
);
	import twa_pkg::*;

	logic [DATA_W-1:0]        mem [MAX_WINDOW];
	logic [WIN_W-1:0]         window_q;
	logic [WIN_W-1:0]         w_eff;
	logic [SLOT_W-1:0]        slot_q;
	logic [SLOT_W-1:0]        rd_addr;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SUM_W-1:0]  sum_next;
	logic [WIN_W-1:0]         seen_q;
	logic                     full;
	logic [DATA_W-1:0]        sample_q;
	logic                     last_q;
	logic [DATA_W-1:0]        old_q;
	logic [NUM_W-1:0]         num_q;
	logic [DEN_W-1:0]         rem_q;
	logic [DEN_W-1:0]         den_q;
	logic                     neg_q;
	logic [DEN_W:0]           trial;
	logic                     qbit;
	logic [SUM_W-1:0]         mag;
	logic [DATA_W-1:0]        quo;
	logic signed [DATA_W-1:0] average_q;
	logic                     too_few_q;

	always_comb begin
		if (window_q == '0) begin
			w_eff = WIN_W'(1);
		end else if (window_q > WIN_W'(MAX_WINDOW)) begin
			w_eff = WIN_W'(MAX_WINDOW);
		end else begin
			w_eff = window_q;
		end
	end

	assign rd_addr = slot_q - w_eff[SLOT_W-1:0];
	assign full    = (seen_q >= w_eff);

	always_comb begin
		if (full) begin
			sum_next = sum_q + SUM_W'(signed'(sample_q)) - SUM_W'(signed'(old_q));
		end else begin
			sum_next = sum_q + SUM_W'(signed'(sample_q));
		end
	end

	assign status.last    = last_q;
	assign status.too_few = !full && ({1'b0, seen_q} + (WIN_W+1)'(1) < {1'b0, w_eff});

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});
	assign mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign quo   = num_q[DATA_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem[slot_q] <= sample_q;
		end
		if (cmd.accept) begin
			old_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_W'(WINDOW_RESET);
			slot_q   <= '0;
			sum_q    <= '0;
			seen_q   <= '0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_data;
				sum_q    <= '0;
				seen_q   <= '0;
			end else if (cmd.update) begin
				slot_q <= slot_q + SLOT_W'(1);
				if (last_q && status.too_few) begin
					sum_q  <= '0;
					seen_q <= '0;
				end else begin
					sum_q <= sum_next;
					if (!full) begin
						seen_q <= seen_q + WIN_W'(1);
					end
				end
			end else if (cmd.load) begin
				sum_q  <= '0;
				seen_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
			last_q   <= is_last;
		end
		if (cmd.load) begin
			neg_q <= sum_q[SUM_W-1];
			num_q <= {mag, 1'b0} + NUM_W'(w_eff);
			den_q <= {w_eff, 1'b0};
			rem_q <= '0;
		end else if (cmd.step) begin
			rem_q <= qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], qbit};
		end
		if (cmd.flag) begin
			average_q <= '0;
			too_few_q <= 1'b1;
		end else if (cmd.finish) begin
			average_q <= neg_q ? signed'(-quo) : signed'(quo);
			too_few_q <= 1'b0;
		end
	end

	assign average = average_q;
	assign too_few = too_few_q;

	`TWA_ASSERT_SAME(a_seen_bound, cmd.update, seen_q <= w_eff, "count above window")
	`TWA_ASSERT_NEXT(a_load_clears, cmd.load, sum_q == '0 && seen_q == '0, "run not cleared")
	`TWA_ASSERT_SAME(a_rem_bound, cmd.step, rem_q < den_q, "remainder out of range")

endmodule

// ----- design/twa_ctrl.sv -----
// Controller: sequences accept, window update, divide and result strobe.
`include "trailing_window_average_core_macros.svh"

module twa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	output logic                  cfg_ready,
	output twa_pkg::twa_cmd_t     cmd,
	input  twa_pkg::twa_status_t  status
);
	import twa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_LOAD,
		ST_DIVIDE,
		ST_SIGN
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == ST_IDLE) && start;
		cmd.update = (state_q == ST_UPDATE);
		cmd.flag   = (state_q == ST_UPDATE) && status.last && status.too_few;
		cmd.load   = (state_q == ST_LOAD);
		cmd.step   = (state_q == ST_DIVIDE);
		cmd.finish = (state_q == ST_SIGN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (!status.last) begin
						state_q <= ST_IDLE;
					end else if (status.too_few) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign done      = done_q;

	`TWA_ASSERT_NEXT(a_accept_update, cmd.accept, state_q == ST_UPDATE, "accept not followed by update")
	`TWA_ASSERT_NEXT(a_sign_done, cmd.finish, done_q && state_q == ST_IDLE, "no strobe after divide")
	`TWA_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "strobe longer than one cycle")
	`TWA_ASSERT_SAME(a_cnt_bound, state_q == ST_DIVIDE, cnt_q < DIV_CNT_W'(DIV_STEPS), "divide count overrun")

endmodule
